FILE: rtl/mvna_pkg.sv
// Shared types, widths and codes of the mesh vertex normal accumulator.
// Used by the front, the normalizer, the back end and the top level.
package mvna_pkg;

    // Field widths fixed by the interface.
    localparam int IDX_W = 10;
    localparam int POS_W = 24;
    localparam int SUM_W = 24;
    localparam int NRM_W = 16;

    // Datapath widths: edges, cross products and normalizer internals.
    localparam int EDGE_W = POS_W + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int CR_W   = PROD_W + 1;
    localparam int MAG_W  = CR_W;
    localparam int SQI_W  = 30;
    localparam int SQ_W   = 2 * SQI_W;
    localparam int S_W    = SQ_W + 2;
    localparam int BIT_W  = S_W + 1;
    localparam int LEN_W  = SQI_W + 1;
    localparam int Q_W    = 15;
    localparam int FRAC_W = 14;
    localparam int NUM_W  = SQI_W + Q_W;
    localparam int REM_W  = LEN_W + 1;

    // Defaults and queue sizing.
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Saturation limits of the normal sums and the unit length in Q1.14.
    localparam logic signed [SUM_W:0] SUM_HI = 25'sd8388607;
    localparam logic signed [SUM_W:0] SUM_LO = -25'sd8388608;
    localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

    // Command codes on the input port.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Classified operation carried from front to back.
    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_TRI       = 2'd1,
        OP_READ      = 2'd2,
        OP_READ_ZERO = 2'd3
    } t_op;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_xyz;

    typedef struct packed {
        t_op             op;
        logic [IDX_W-1:0] idx0;
        logic [IDX_W-1:0] idx1;
        logic [IDX_W-1:0] idx2;
        t_xyz            pos;
    } t_qent;

endpackage

FILE: rtl/mesh_vertex_normal_accumulator.sv
// Top level of the mesh vertex normal accumulator; depends on mvna_pkg, mvna_front, mvna_back.
// Items leave the queue one at a time: a load writes its position and clears its sum, a read
// normalizes the vertex sum, and a triangle forms its cross product, normalizes it and updates
// its three corner sums. The normalizer shifts, squares, takes the root bit by bit and divides
// each component in turn. Items run one at a time; loads sustain one per cycle. Reset:
// synchronous, active low; a clearing pass then zeroes the sums, with full held high.
module mesh_vertex_normal_accumulator #(
    parameter int MAX_VERTICES = mvna_pkg::MAX_VERTICES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_command,
    input  logic [mvna_pkg::IDX_W-1:0]         i_vertex_index,
    input  logic signed [mvna_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [mvna_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [mvna_pkg::POS_W-1:0]  i_pos_z,
    input  logic [mvna_pkg::IDX_W-1:0]         i_corner_a,
    input  logic [mvna_pkg::IDX_W-1:0]         i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]         i_corner_c,
    output logic                               empty,
    input  logic                               pop,
    output logic [mvna_pkg::IDX_W-1:0]         o_out_vertex,
    output logic signed [mvna_pkg::NRM_W-1:0]  o_normal_x,
    output logic signed [mvna_pkg::NRM_W-1:0]  o_normal_y,
    output logic signed [mvna_pkg::NRM_W-1:0]  o_normal_z,
    output logic                               o_is_zero
);

    logic            q_valid;
    logic            q_pop;
    logic            clearing;
    mvna_pkg::t_qent q_ent;

    // Front: accept and classify.
    mvna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .i_clearing     (clearing),
        .o_q_valid      (q_valid),
        .o_q_ent        (q_ent),
        .i_q_pop        (q_pop)
    );

    // Back: memories, arithmetic and result register.
    mvna_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_ent      (q_ent),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .empty        (empty),
        .pop          (pop),
        .o_out_vertex (o_out_vertex),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_is_zero    (o_is_zero)
    );

endmodule

FILE: rtl/mvna_front.sv
// Front end: accepts input beats, classifies them and queues the work for the back end.
// Depends on mvna_pkg.
module mvna_front #(
    parameter int MAX_VERTICES = mvna_pkg::MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_command,
    input  logic [mvna_pkg::IDX_W-1:0]      i_vertex_index,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_z,
    input  logic [mvna_pkg::IDX_W-1:0]      i_corner_a,
    input  logic [mvna_pkg::IDX_W-1:0]      i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]      i_corner_c,
    input  logic                            i_clearing,
    output logic                            o_q_valid,
    output mvna_pkg::t_qent                 o_q_ent,
    input  logic                            i_q_pop
);

    mvna_pkg::t_qent r_fifo [mvna_pkg::QDEPTH];
    logic [mvna_pkg::QPTR_W-1:0] r_wr;
    logic [mvna_pkg::QPTR_W-1:0] r_rd;
    logic [mvna_pkg::QPTR_W:0]   r_count;
    mvna_pkg::t_qent ent;
    logic keep;
    logic wr;
    logic rd;

    function automatic logic in_range(input logic [mvna_pkg::IDX_W-1:0] idx);
        return {22'b0, idx} < 32'(MAX_VERTICES);
    endfunction

    // Classify the beat: drop unused commands and out-of-range loads and triangles.
    always_comb begin
        ent.op   = mvna_pkg::OP_LOAD;
        ent.idx0 = i_vertex_index;
        ent.idx1 = i_corner_b;
        ent.idx2 = i_corner_c;
        ent.pos  = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
        keep     = 1'b0;
        case (i_command)
            mvna_pkg::CMD_LOAD: begin
                keep = in_range(i_vertex_index);
            end
            mvna_pkg::CMD_TRI: begin
                ent.op   = mvna_pkg::OP_TRI;
                ent.idx0 = i_corner_a;
                keep     = in_range(i_corner_a) && in_range(i_corner_b)
                           && in_range(i_corner_c);
            end
            mvna_pkg::CMD_READ: begin
                ent.op = in_range(i_vertex_index) ? mvna_pkg::OP_READ
                                                  : mvna_pkg::OP_READ_ZERO;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Queue full also covers the sum clearing pass after reset.
    assign full      = (r_count == (mvna_pkg::QPTR_W + 1)'(mvna_pkg::QDEPTH)) || i_clearing;
    assign wr        = push && !full && keep;
    assign o_q_valid = (r_count != '0);
    assign rd        = i_q_pop && o_q_valid;
    assign o_q_ent   = r_fifo[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_fifo[r_wr] <= ent;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (mvna_pkg::QPTR_W + 1)'(mvna_pkg::QDEPTH))
        else $error("front queue count exceeds depth");

endmodule

FILE: rtl/mvna_norm.sv
// Iterative normalizer: scales a 3-vector to a Q1.14 unit vector with a bit-serial
// square root and a restoring divider. Depends on mvna_pkg.
module mvna_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [mvna_pkg::CR_W-1:0]   i_c [3],
    output logic                               o_done,
    output logic signed [mvna_pkg::NRM_W-1:0]  o_n [3],
    output logic                               o_zero
);

    localparam int MAG_W = mvna_pkg::MAG_W;
    localparam logic [MAG_W-1:0] TH25 = MAG_W'(64'd1 << 25);
    localparam logic [MAG_W-1:0] TH29 = MAG_W'(64'd1 << 29);
    localparam logic [MAG_W-1:0] TH30 = MAG_W'(64'd1 << 30);
    localparam logic [MAG_W-1:0] TH34 = MAG_W'(64'd1 << 34);
    localparam logic [3:0] DIV_LAST = 4'(mvna_pkg::Q_W - 1);

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SHIFT = 7'b0000010,
        N_SQ    = 7'b0000100,
        N_SQEND = 7'b0001000,
        N_ROOT  = 7'b0010000,
        N_DLOAD = 7'b0100000,
        N_DIV   = 7'b1000000
    } t_nstate;

    t_nstate r_state;
    t_nstate n_state;
    logic [MAG_W-1:0] r_mag [3];
    logic             r_neg [3];
    logic [1:0]       r_k;
    logic [mvna_pkg::SQ_W-1:0]  r_prod;
    logic [mvna_pkg::S_W-1:0]   r_s;
    logic [mvna_pkg::BIT_W-1:0] r_res;
    logic [mvna_pkg::BIT_W-1:0] r_bit;
    logic [mvna_pkg::LEN_W-1:0] r_len;
    logic [mvna_pkg::REM_W-1:0] r_rem;
    logic [mvna_pkg::Q_W-1:0]   r_low;
    logic [mvna_pkg::Q_W-1:0]   r_q;
    logic [3:0]                 r_cnt;
    logic signed [mvna_pkg::NRM_W-1:0] r_n [3];
    logic r_zero;
    logic r_done;

    logic [MAG_W-1:0] mx;
    logic [mvna_pkg::SQI_W-1:0] msel;
    logic [mvna_pkg::SQ_W-1:0]  sq;
    logic [mvna_pkg::BIT_W-1:0] rt_t;
    logic                       rt_ge;
    logic [mvna_pkg::BIT_W-1:0] res_next;
    logic [mvna_pkg::NUM_W-1:0] num;
    logic [mvna_pkg::REM_W-1:0] rem2;
    logic                       dv_ge;
    logic [mvna_pkg::Q_W-1:0]   qn;
    logic                       zero_vec;
    logic                       div_end;

    // Largest magnitude decides the common shift.
    always_comb begin
        mx = r_mag[0];
        if (r_mag[1] > mx) begin
            mx = r_mag[1];
        end
        if (r_mag[2] > mx) begin
            mx = r_mag[2];
        end
    end

    // One square per cycle, one root bit per cycle, one quotient bit per cycle.
    assign msel     = r_mag[r_k][mvna_pkg::SQI_W-1:0];
    assign sq       = msel * msel;
    assign rt_t     = r_res + r_bit;
    assign rt_ge    = {1'b0, r_s} >= rt_t;
    assign res_next = rt_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    assign num      = {msel, {mvna_pkg::FRAC_W{1'b0}}} + mvna_pkg::NUM_W'(r_len >> 1);
    assign rem2     = {r_rem[mvna_pkg::REM_W-2:0], r_low[mvna_pkg::Q_W-1]};
    assign dv_ge    = rem2 >= mvna_pkg::REM_W'(r_len);
    assign qn       = {r_q[mvna_pkg::Q_W-2:0], dv_ge};
    assign zero_vec = (mx == '0);
    assign div_end  = (r_cnt == DIV_LAST);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    n_state = N_SHIFT;
                end
            end
            N_SHIFT: begin
                if (zero_vec) begin
                    n_state = N_IDLE;
                end else if (mx >= TH29 && mx < TH30) begin
                    n_state = N_SQ;
                end
            end
            N_SQ: begin
                if (r_k == 2'd2) begin
                    n_state = N_SQEND;
                end
            end
            N_SQEND: begin
                n_state = N_ROOT;
            end
            N_ROOT: begin
                if (r_bit[0]) begin
                    n_state = N_DLOAD;
                end
            end
            N_DLOAD: begin
                n_state = N_DIV;
            end
            N_DIV: begin
                if (div_end) begin
                    n_state = (r_k == 2'd2) ? N_IDLE : N_DLOAD;
                end
            end
            default: begin
                n_state = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == N_SHIFT && zero_vec)
                       || (r_state == N_DIV && div_end && r_k == 2'd2);
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= i_c[i][mvna_pkg::CR_W-1];
                        r_mag[i] <= i_c[i][mvna_pkg::CR_W-1] ? MAG_W'(-i_c[i])
                                                               : MAG_W'(i_c[i]);
                    end
                    r_zero <= 1'b0;
                    r_k    <= '0;
                    r_s    <= '0;
                end
            end
            N_SHIFT: begin
                if (zero_vec) begin
                    r_zero <= 1'b1;
                    r_n    <= '{default: '0};
                end else if (mx >= TH34) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 4;
                end else if (mx >= TH30) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end else if (mx < TH25) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 4;
                end else if (mx < TH29) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                end
            end
            N_SQ: begin
                r_prod <= sq;
                if (r_k != 2'd0) begin
                    r_s <= r_s + mvna_pkg::S_W'(r_prod);
                end
                r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            N_SQEND: begin
                r_s   <= r_s + mvna_pkg::S_W'(r_prod);
                r_res <= '0;
                r_bit <= mvna_pkg::BIT_W'(1) << (mvna_pkg::BIT_W - 1);
            end
            N_ROOT: begin
                if (rt_ge) begin
                    r_s <= r_s - rt_t[mvna_pkg::S_W-1:0];
                end
                r_res <= res_next;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_len <= res_next[mvna_pkg::LEN_W-1:0];
                end
            end
            N_DLOAD: begin
                r_rem <= mvna_pkg::REM_W'(num[mvna_pkg::NUM_W-1:mvna_pkg::Q_W]);
                r_low <= num[mvna_pkg::Q_W-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            N_DIV: begin
                r_rem <= dv_ge ? (rem2 - mvna_pkg::REM_W'(r_len)) : rem2;
                r_low <= r_low << 1;
                r_q   <= qn;
                r_cnt <= r_cnt + 4'd1;
                if (div_end) begin
                    r_n[r_k] <= r_neg[r_k] ? -mvna_pkg::NRM_W'(qn) : mvna_pkg::NRM_W'(qn);
                    r_k      <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
            end
            default: begin
                r_k <= '0;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_n    = r_n;
    assign o_zero = r_zero;

    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == N_SQ |-> (mx >= TH29 && mx < TH30))
        else $error("normalizer shift left the maximum out of range");

    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == N_DIV |-> r_rem < mvna_pkg::REM_W'(r_len))
        else $error("divider remainder not below the length");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_n[0] <= mvna_pkg::ONE_Q14 && r_n[0] >= -mvna_pkg::ONE_Q14
                    && r_n[1] <= mvna_pkg::ONE_Q14 && r_n[1] >= -mvna_pkg::ONE_Q14
                    && r_n[2] <= mvna_pkg::ONE_Q14 && r_n[2] >= -mvna_pkg::ONE_Q14))
        else $error("normalized component exceeds one");

endmodule

FILE: rtl/mvna_back.sv
// Back end: position and sum memories, cross product, corner updates and the result register.
// Depends on mvna_pkg and mvna_norm.
module mvna_back #(
    parameter int MAX_VERTICES = mvna_pkg::MAX_VERTICES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  mvna_pkg::t_qent                    i_q_ent,
    output logic                               o_q_pop,
    output logic                               o_clearing,
    output logic                               empty,
    input  logic                               pop,
    output logic [mvna_pkg::IDX_W-1:0]         o_out_vertex,
    output logic signed [mvna_pkg::NRM_W-1:0]  o_normal_x,
    output logic signed [mvna_pkg::NRM_W-1:0]  o_normal_y,
    output logic signed [mvna_pkg::NRM_W-1:0]  o_normal_z,
    output logic                               o_is_zero
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int SW1 = mvna_pkg::SUM_W + 1;

    typedef enum logic [10:0] {
        B_CLEAR = 11'b00000000001,
        B_IDLE  = 11'b00000000010,
        B_TA    = 11'b00000000100,
        B_TB    = 11'b00000001000,
        B_TC    = 11'b00000010000,
        B_MUL   = 11'b00000100000,
        B_NORM  = 11'b00001000000,
        B_CRD   = 11'b00010000000,
        B_CWR   = 11'b00100000000,
        B_SRD   = 11'b01000000000,
        B_OUT   = 11'b10000000000
    } t_bstate;

    t_bstate r_state;
    t_bstate n_state;
    mvna_pkg::t_qent r_ent;
    mvna_pkg::t_xyz  r_pos_mem [MAX_VERTICES];
    mvna_pkg::t_xyz  r_sum_mem [MAX_VERTICES];
    mvna_pkg::t_xyz  r_pos_rd;
    mvna_pkg::t_xyz  r_sum_rd;
    mvna_pkg::t_xyz  r_pa;
    mvna_pkg::t_xyz  r_pb;
    logic signed [mvna_pkg::EDGE_W-1:0] r_e1 [3];
    logic signed [mvna_pkg::EDGE_W-1:0] r_e2 [3];
    logic [2:0] r_mk;
    logic signed [mvna_pkg::PROD_W-1:0] r_prod;
    logic signed [mvna_pkg::CR_W-1:0]   r_cr [3];
    logic [1:0] r_j;
    logic signed [mvna_pkg::NRM_W-1:0] r_n [3];
    logic r_zero;
    logic [AW-1:0] r_clr;
    logic r_ovalid;
    logic [mvna_pkg::IDX_W-1:0] r_overt;
    logic signed [mvna_pkg::NRM_W-1:0] r_on [3];
    logic r_ozero;

    logic pos_we;
    logic [AW-1:0] pos_wa;
    logic [AW-1:0] pos_ra;
    logic sum_we;
    logic [AW-1:0] sum_wa;
    logic [AW-1:0] sum_ra;
    mvna_pkg::t_xyz sum_wd;
    mvna_pkg::t_xyz sum_sat;
    logic [mvna_pkg::IDX_W-1:0] corner;
    logic signed [mvna_pkg::EDGE_W-1:0] mul_a;
    logic signed [mvna_pkg::EDGE_W-1:0] mul_b;
    logic [2:0] mk_m1;
    logic [1:0] cr_idx;
    logic norm_start;
    logic signed [mvna_pkg::CR_W-1:0] norm_c [3];
    logic norm_done;
    logic signed [mvna_pkg::NRM_W-1:0] norm_n [3];
    logic norm_zero;
    logic out_free;

    function automatic logic signed [mvna_pkg::SUM_W-1:0] sat_add(
        input logic signed [mvna_pkg::SUM_W-1:0] a,
        input logic signed [mvna_pkg::NRM_W-1:0] b
    );
        logic signed [mvna_pkg::SUM_W:0] s;
        s = SW1'(a) + SW1'(b);
        if (s > mvna_pkg::SUM_HI) begin
            return mvna_pkg::SUM_HI[mvna_pkg::SUM_W-1:0];
        end else if (s < mvna_pkg::SUM_LO) begin
            return mvna_pkg::SUM_LO[mvna_pkg::SUM_W-1:0];
        end
        return mvna_pkg::SUM_W'(s);
    endfunction

    function automatic logic signed [mvna_pkg::CR_W-1:0] sext_sum(
        input logic signed [mvna_pkg::SUM_W-1:0] v
    );
        return {{(mvna_pkg::CR_W - mvna_pkg::SUM_W){v[mvna_pkg::SUM_W-1]}}, v};
    endfunction

    assign o_clearing = (r_state == B_CLEAR);
    assign o_q_pop    = (r_state == B_IDLE) && i_q_valid;
    assign out_free   = !r_ovalid || pop;
    assign mk_m1      = r_mk - 3'd1;
    assign cr_idx     = 2'(mk_m1 >> 1);

    // Triangle corner under update.
    always_comb begin
        case (r_j)
            2'd0:    corner = r_ent.idx0;
            2'd1:    corner = r_ent.idx1;
            default: corner = r_ent.idx2;
        endcase
    end

    // Cross product operand order: y*z, z*y, z*x, x*z, x*y, y*x.
    always_comb begin
        case (r_mk)
            3'd0:    begin mul_a = r_e1[1]; mul_b = r_e2[2]; end
            3'd1:    begin mul_a = r_e1[2]; mul_b = r_e2[1]; end
            3'd2:    begin mul_a = r_e1[2]; mul_b = r_e2[0]; end
            3'd3:    begin mul_a = r_e1[0]; mul_b = r_e2[2]; end
            3'd4:    begin mul_a = r_e1[0]; mul_b = r_e2[1]; end
            3'd5:    begin mul_a = r_e1[1]; mul_b = r_e2[0]; end
            default: begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    // Saturating update of one corner sum.
    assign sum_sat.x = sat_add(r_sum_rd.x, r_n[0]);
    assign sum_sat.y = sat_add(r_sum_rd.y, r_n[1]);
    assign sum_sat.z = sat_add(r_sum_rd.z, r_n[2]);

    // Memory port addresses and writes.
    always_comb begin
        pos_we = 1'b0;
        pos_wa = AW'(i_q_ent.idx0);
        pos_ra = AW'(i_q_ent.idx0);
        sum_we = 1'b0;
        sum_wa = AW'(i_q_ent.idx0);
        sum_ra = AW'(i_q_ent.idx0);
        sum_wd = '0;
        case (r_state)
            B_CLEAR: begin
                sum_we = 1'b1;
                sum_wa = r_clr;
            end
            B_IDLE: begin
                if (i_q_valid && i_q_ent.op == mvna_pkg::OP_LOAD) begin
                    pos_we = 1'b1;
                    sum_we = 1'b1;
                end
            end
            B_TA: begin
                pos_ra = AW'(r_ent.idx1);
            end
            B_TB: begin
                pos_ra = AW'(r_ent.idx2);
            end
            B_CRD: begin
                sum_ra = AW'(corner);
            end
            B_CWR: begin
                sum_we = 1'b1;
                sum_wa = AW'(corner);
                sum_wd = sum_sat;
            end
            default: begin
                pos_we = 1'b0;
            end
        endcase
    end

    // Position memory.
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_wa] <= i_q_ent.pos;
        end
        r_pos_rd <= r_pos_mem[pos_ra];
    end

    // Normal sum memory.
    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_sum_mem[sum_wa] <= sum_wd;
        end
        r_sum_rd <= r_sum_mem[sum_ra];
    end

    // Normalizer input and start; a face starts once the last cross term has folded in.
    assign norm_start = (r_state == B_MUL && r_mk == 3'd7) || (r_state == B_SRD);
    always_comb begin
        if (r_ent.op == mvna_pkg::OP_TRI) begin
            norm_c = r_cr;
        end else begin
            norm_c[0] = sext_sum(r_sum_rd.x);
            norm_c[1] = sext_sum(r_sum_rd.y);
            norm_c[2] = sext_sum(r_sum_rd.z);
        end
    end

    mvna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_c     (norm_c),
        .o_done  (norm_done),
        .o_n     (norm_n),
        .o_zero  (norm_zero)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: begin
                if (r_clr == AW'(MAX_VERTICES - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_ent.op)
                        mvna_pkg::OP_TRI:       n_state = B_TA;
                        mvna_pkg::OP_READ:      n_state = B_SRD;
                        mvna_pkg::OP_READ_ZERO: n_state = B_OUT;
                        default:                n_state = B_IDLE;
                    endcase
                end
            end
            B_TA:  n_state = B_TB;
            B_TB:  n_state = B_TC;
            B_TC:  n_state = B_MUL;
            B_MUL: begin
                if (r_mk == 3'd7) begin
                    n_state = B_NORM;
                end
            end
            B_NORM: begin
                if (norm_done) begin
                    n_state = (r_ent.op == mvna_pkg::OP_TRI) ? B_CRD : B_OUT;
                end
            end
            B_CRD: n_state = B_CWR;
            B_CWR: n_state = (r_j == 2'd2) ? B_IDLE : B_CRD;
            B_SRD: n_state = B_NORM;
            B_OUT: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control registers, including the clearing pass and the result flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == B_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_ent <= i_q_ent;
                r_mk  <= '0;
                r_j   <= '0;
                if (i_q_valid && i_q_ent.op == mvna_pkg::OP_READ_ZERO) begin
                    r_n    <= '{default: '0};
                    r_zero <= 1'b1;
                end
            end
            B_TA: begin
                r_pa <= r_pos_rd;
            end
            B_TB: begin
                r_pb <= r_pos_rd;
            end
            B_TC: begin
                r_e1[0] <= mvna_pkg::EDGE_W'(r_pb.x) - mvna_pkg::EDGE_W'(r_pa.x);
                r_e1[1] <= mvna_pkg::EDGE_W'(r_pb.y) - mvna_pkg::EDGE_W'(r_pa.y);
                r_e1[2] <= mvna_pkg::EDGE_W'(r_pb.z) - mvna_pkg::EDGE_W'(r_pa.z);
                r_e2[0] <= mvna_pkg::EDGE_W'(r_pos_rd.x) - mvna_pkg::EDGE_W'(r_pb.x);
                r_e2[1] <= mvna_pkg::EDGE_W'(r_pos_rd.y) - mvna_pkg::EDGE_W'(r_pb.y);
                r_e2[2] <= mvna_pkg::EDGE_W'(r_pos_rd.z) - mvna_pkg::EDGE_W'(r_pb.z);
            end
            B_MUL: begin
                // One product per cycle; the previous product folds into its component.
                r_prod <= mul_a * mul_b;
                if (r_mk != 3'd0 && r_mk != 3'd7) begin
                    if (!mk_m1[0]) begin
                        r_cr[cr_idx] <= mvna_pkg::CR_W'(r_prod);
                    end else begin
                        r_cr[cr_idx] <= r_cr[cr_idx] - mvna_pkg::CR_W'(r_prod);
                    end
                end
                r_mk <= r_mk + 3'd1;
            end
            B_NORM: begin
                if (norm_done) begin
                    r_n    <= norm_n;
                    r_zero <= norm_zero;
                end
            end
            B_CWR: begin
                r_j <= r_j + 2'd1;
            end
            B_OUT: begin
                if (out_free) begin
                    r_overt <= r_ent.idx0;
                    r_on    <= r_n;
                    r_ozero <= r_zero;
                end
            end
            default: begin
                r_j <= r_j;
            end
        endcase
    end

    assign empty        = !r_ovalid;
    assign o_out_vertex = r_overt;
    assign o_normal_x   = r_on[0];
    assign o_normal_y   = r_on[1];
    assign o_normal_z   = r_on[2];
    assign o_is_zero    = r_ozero;

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == B_OUT))
        else $error("result register loaded outside the output step");

    a_corner_only_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_CWR |-> r_ent.op == mvna_pkg::OP_TRI)
        else $error("corner sum written for a non-triangle item");

endmodule

FILE: tb/mesh_vertex_normal_accumulator_tb.sv
// Self-checking testbench of the mesh vertex normal accumulator: load, triangle and read beats.
// Depends on mvna_pkg and mesh_vertex_normal_accumulator; predicts every normal read.
module mesh_vertex_normal_accumulator_tb;

    localparam int NVERT = 1024;
    localparam int STALL_LIMIT = 20000;
    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] cmd;
        logic [mvna_pkg::IDX_W-1:0] vi;
        logic signed [mvna_pkg::POS_W-1:0] px, py, pz;
        logic [mvna_pkg::IDX_W-1:0] ca, cb, cc;
    } t_beat;

    typedef struct {
        logic [mvna_pkg::IDX_W-1:0] vi;
        logic signed [mvna_pkg::NRM_W-1:0] nx, ny, nz;
        logic zero;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic [1:0] i_command = '0;
    logic [mvna_pkg::IDX_W-1:0] i_vertex_index = '0;
    logic signed [mvna_pkg::POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [mvna_pkg::IDX_W-1:0] i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic full, empty, o_is_zero;
    logic [mvna_pkg::IDX_W-1:0] o_out_vertex;
    logic signed [mvna_pkg::NRM_W-1:0] o_normal_x, o_normal_y, o_normal_z;

    mesh_vertex_normal_accumulator uut (.*);

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    longint vert_x[NVERT], vert_y[NVERT], vert_z[NVERT];
    longint sum_x[NVERT], sum_y[NVERT], sum_z[NVERT];
    bit loaded[NVERT];
    t_beat pending_beats[$];
    t_normal expected_normals[$];
    int fail_count = 0;
    bit stim_done = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    bit quiet_stretch = 0;
    bit in_fire = 0;

    function automatic longint isqrt(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scales a vector to a Q1.14 unit normal; returns 1 for the zero vector.
    function automatic bit unit_normal(input longint c[3], output longint n[3]);
        longint unsigned mag[3], m, s, len, q;
        bit neg[3];
        int rsh, lsh;
        m = 0; s = 0; rsh = 0; lsh = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i] < 0;
            mag[i] = neg[i] ? -c[i] : c[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            n = '{0, 0, 0};
            return 1;
        end
        while ((m >> rsh) >= (64'd1 << 30)) rsh++;
        while (rsh == 0 && (m << lsh) < (64'd1 << 29)) lsh++;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (mag[i] >> rsh) << lsh;
            s += mag[i] * mag[i];
        end
        len = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + (len >> 1)) / len;
            n[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 0;
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        longint r;
        r = a + b;
        if (r > 8388607) return 8388607;
        if (r < -8388608) return -8388608;
        return r;
    endfunction

    // Applies one accepted beat to the predictor, queuing a normal on reads.
    task automatic predict_beat(t_beat b);
        longint e1[3], e2[3], cr[3], n[3];
        int v[3];
        t_normal r;
        case (b.cmd)
            mvna_pkg::CMD_LOAD: begin
                vert_x[b.vi] = longint'(b.px);
                vert_y[b.vi] = longint'(b.py);
                vert_z[b.vi] = longint'(b.pz);
                sum_x[b.vi] = 0; sum_y[b.vi] = 0; sum_z[b.vi] = 0;
            end
            mvna_pkg::CMD_TRI: begin
                v = '{int'(b.ca), int'(b.cb), int'(b.cc)};
                e1 = '{vert_x[v[1]] - vert_x[v[0]], vert_y[v[1]] - vert_y[v[0]],
                       vert_z[v[1]] - vert_z[v[0]]};
                e2 = '{vert_x[v[2]] - vert_x[v[1]], vert_y[v[2]] - vert_y[v[1]],
                       vert_z[v[2]] - vert_z[v[1]]};
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                void'(unit_normal(cr, n));
                for (int i = 0; i < 3; i++) begin
                    sum_x[v[i]] = sat_sum(sum_x[v[i]], n[0]);
                    sum_y[v[i]] = sat_sum(sum_y[v[i]], n[1]);
                    sum_z[v[i]] = sat_sum(sum_z[v[i]], n[2]);
                end
            end
            mvna_pkg::CMD_READ: begin
                cr = '{sum_x[b.vi], sum_y[b.vi], sum_z[b.vi]};
                r.zero = unit_normal(cr, n);
                r.vi = b.vi;
                r.nx = mvna_pkg::NRM_W'(n[0]);
                r.ny = mvna_pkg::NRM_W'(n[1]);
                r.nz = mvna_pkg::NRM_W'(n[2]);
                expected_normals.insert(expected_normals.size(), r);
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [mvna_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return mvna_pkg::POS_W'(int'($urandom_range(0, 255)) - 128);
            default: return mvna_pkg::POS_W'($urandom());
        endcase
    endfunction

    // Builds a beat with random positions and the given command, index and corners.
    function automatic t_beat make_beat(logic [1:0] cmd, int vi, int ca, int cb, int cc);
        t_beat b;
        b.cmd = cmd; b.vi = mvna_pkg::IDX_W'(vi);
        b.px = rand_pos(); b.py = rand_pos(); b.pz = rand_pos();
        b.ca = mvna_pkg::IDX_W'(ca);
        b.cb = mvna_pkg::IDX_W'(cb);
        b.cc = mvna_pkg::IDX_W'(cc);
        return b;
    endfunction

    // Loaded index, mostly from a small working set so reads and triangles meet.
    function automatic int pick_loaded();
        int v;
        do v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NVERT - 1)
                                           : $urandom_range(0, 31);
        while (!loaded[v]);
        return v;
    endfunction

    task automatic queue_beat(t_beat b);
        if (b.cmd == mvna_pkg::CMD_LOAD) loaded[b.vi] = 1;
        pending_beats.insert(pending_beats.size(), b);
    endtask

    // Stimulus generation.
    initial begin
        t_beat b;
        int k;
        queue_beat(make_beat(mvna_pkg::CMD_READ, 0, 0, 0, 0));
        b = make_beat(mvna_pkg::CMD_LOAD, 0, 0, 0, 0); b.px = '0; b.py = '0; b.pz = '0;
        queue_beat(b);
        b = make_beat(mvna_pkg::CMD_LOAD, 1, 0, 0, 0); b.px = 24'sh7FFFFF; b.py = '0;
        b.pz = '0; queue_beat(b);
        b = make_beat(mvna_pkg::CMD_LOAD, 2, 0, 0, 0); b.px = '0; b.py = 24'sh800000;
        b.pz = '0; queue_beat(b);
        b = make_beat(mvna_pkg::CMD_LOAD, 1023, 0, 0, 0); b.px = 24'sh800000;
        b.py = 24'sh7FFFFF; b.pz = 24'sh800000; queue_beat(b);
        queue_beat(make_beat(mvna_pkg::CMD_TRI, 0, 0, 1, 2));
        queue_beat(make_beat(mvna_pkg::CMD_TRI, 0, 0, 1, 1023));
        queue_beat(make_beat(mvna_pkg::CMD_TRI, 0, 0, 0, 1));       // degenerate face
        queue_beat(make_beat(mvna_pkg::CMD_TRI, 0, 1, 1, 2));       // repeated corner
        queue_beat(make_beat(mvna_pkg::CMD_READ, 0, 0, 0, 0));
        queue_beat(make_beat(mvna_pkg::CMD_READ, 1023, 0, 0, 0));
        queue_beat(make_beat(mvna_pkg::CMD_READ, 5, 0, 0, 0));      // never touched: zero sum
        // Repeat a degenerate face on corners 1023, 1023 and 1.
        for (k = 0; k < 6; k++) queue_beat(make_beat(mvna_pkg::CMD_TRI, 0, 1023, 1023, 1));
        queue_beat(make_beat(CMD_UNUSED, 1023, 1023, 1023, 1023));
        queue_beat(make_beat(mvna_pkg::CMD_READ, 1023, 0, 0, 0));
        queue_beat(make_beat(mvna_pkg::CMD_READ, 1, 0, 0, 0));
        for (k = 3; k < 32; k++) queue_beat(make_beat(mvna_pkg::CMD_LOAD, k, 0, 0, 0));
        // Random mix of loads, triangles, reads and unused commands, triangles the most common.
        for (k = 0; k < 1650; k++) begin
            case ($urandom_range(0, 9))
                0, 1: queue_beat(make_beat(mvna_pkg::CMD_LOAD, $urandom_range(0, 9) == 0 ?
                          $urandom_range(0, NVERT - 1) : $urandom_range(0, 31), 0, 0, 0));
                2, 3, 4, 5: queue_beat(make_beat(mvna_pkg::CMD_TRI, $urandom(), pick_loaded(),
                          pick_loaded(), pick_loaded()));
                9: if ($urandom_range(0, 3) == 0) queue_beat(make_beat(CMD_UNUSED, $urandom(),
                          $urandom(), $urandom(), $urandom()));
                   else queue_beat(make_beat(mvna_pkg::CMD_READ, $urandom(), 0, 0, 0));
                default: queue_beat(make_beat(mvna_pkg::CMD_READ, pick_loaded(), 0, 0, 0));
            endcase
        end
        stim_done = 1;
    end

    // Reset sequence.
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
    end

    // Input driver: offers the head beat, idles about 22% of the time outside the quiet stretch.
    always @(negedge i_clk) begin
        if (i_rst_n && (!push || in_fire)) begin
            if (push) void'(pending_beats.pop_front());
            if (pending_beats.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 22))
            begin
                push <= 1'b1;
                i_command <= pending_beats[0].cmd;
                i_vertex_index <= pending_beats[0].vi;
                i_pos_x <= pending_beats[0].px;
                i_pos_y <= pending_beats[0].py;
                i_pos_z <= pending_beats[0].pz;
                i_corner_a <= pending_beats[0].ca;
                i_corner_b <= pending_beats[0].cb;
                i_corner_c <= pending_beats[0].cc;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result side: random pops, one long hold-off, a stretch without idling.
    int recv_cycle = 0;
    always @(negedge i_clk) begin
        recv_cycle <= recv_cycle + 1;
        quiet_stretch <= recv_cycle > 30000 && recv_cycle < 60000;
        if (recv_cycle == 3000) hold_off <= 3000;
        else if (hold_off > 0) hold_off <= hold_off - 1;
        pop <= i_rst_n && hold_off == 0 &&
               (quiet_stretch || $urandom_range(0, 99) >= 22);
    end

    // Monitor: predict on accepted inputs, check on accepted results.
    always @(posedge i_clk) begin
        t_normal e;
        in_fire <= push && !full;
        if (i_rst_n) begin
            if (push && !full) predict_beat(pending_beats[0]);
            if (pop && !empty) begin
                if (expected_normals.size() == 0) begin
                    $error("Unexpected normal beat for vertex %0d", o_out_vertex);
                    fail_count++;
                end else begin
                    e = expected_normals.pop_front();
                    if (o_out_vertex !== e.vi) begin
                        $error("out_vertex expected %0d got %0d", e.vi, o_out_vertex);
                        fail_count++;
                    end
                    if (o_normal_x !== e.nx) begin
                        $error("normal_x expected %0d got %0d", e.nx, o_normal_x);
                        fail_count++;
                    end
                    if (o_normal_y !== e.ny) begin
                        $error("normal_y expected %0d got %0d", e.ny, o_normal_y);
                        fail_count++;
                    end
                    if (o_normal_z !== e.nz) begin
                        $error("normal_z expected %0d got %0d", e.nz, o_normal_z);
                        fail_count++;
                    end
                    if (o_is_zero !== e.zero) begin
                        $error("is_zero expected %0d got %0d", e.zero, o_is_zero);
                        fail_count++;
                    end
                end
            end
            if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run and watchdog.
    initial begin
        wait (stim_done && pending_beats.size() == 0 && !push && expected_normals.size() == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && expected_normals.size() == 0 && empty) begin
            $display("Verification passed");
        end else begin
            if (!empty) $error("Normal beat left over at the end");
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end
endmodule

FILE: mesh_vertex_normal_accumulator.f
rtl/mvna_pkg.sv
rtl/mvna_front.sv
rtl/mvna_norm.sv
rtl/mvna_back.sv
rtl/mesh_vertex_normal_accumulator.sv
tb/mesh_vertex_normal_accumulator_tb.sv
